// ===== hw/rtl/ihcc_pkg.sv =====
// Shared types and constants for the IPv4 header checksum checker.
package ihcc_pkg;

    localparam int CHECKSUM_BYTE_OFFSET = 10;

    localparam int SUM_W   = 21;
    localparam int IDX_W   = 5;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [IDX_W-1:0] CKSUM_WORD   = IDX_W'(CHECKSUM_BYTE_OFFSET / 2);
    localparam logic [IDX_W-1:0] TTL_WORD     = 5'd4;
    localparam logic [3:0]       IHL_MIN      = 4'd5;
    localparam logic [3:0]       VERSION_IPV4 = 4'd4;
    localparam logic [7:0]       TTL_ONE      = 8'd1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [15:0]      received;
        logic             version_good;
        logic             ttl_one;
        logic             malformed;
    } t_rec;

endpackage

// ===== hw/rtl/ihcc_front.sv =====
// Front end: accepts header words, accumulates the sum and emits one record per header.
module ihcc_front
    import ihcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [15:0] i_header_word,
    input  logic        i_start_flag,
    output logic        o_rec_valid,
    output t_rec        o_rec
);

    logic             r_in_header, n_in_header;
    logic [IDX_W-1:0] r_word_index, n_word_index;
    logic [IDX_W-1:0] r_len_words, n_len_words;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [15:0]      r_received, n_received;
    logic             r_version_good, n_version_good;
    logic             r_ttl_one, n_ttl_one;

    logic [3:0] ihl;
    logic       ver4;

    assign ihl  = i_header_word[11:8];
    assign ver4 = (i_header_word[15:12] == VERSION_IPV4);

    always_comb begin
        n_in_header    = r_in_header;
        n_word_index   = r_word_index;
        n_len_words    = r_len_words;
        n_sum          = r_sum;
        n_received     = r_received;
        n_version_good = r_version_good;
        n_ttl_one      = r_ttl_one;
        o_rec_valid    = 1'b0;
        o_rec          = '0;
        if (i_accept) begin
            if (i_start_flag) begin
                if (ihl < IHL_MIN) begin
                    n_in_header        = 1'b0;
                    o_rec_valid        = 1'b1;
                    o_rec.version_good = ver4;
                    o_rec.malformed    = 1'b1;
                end else begin
                    n_in_header    = 1'b1;
                    n_len_words    = {ihl, 1'b0};
                    n_word_index   = 5'd1;
                    n_sum          = {{(SUM_W-16){1'b0}}, i_header_word};
                    n_received     = '0;
                    n_version_good = ver4;
                    n_ttl_one      = 1'b0;
                end
            end else if (r_in_header) begin
                if (r_word_index == CKSUM_WORD) begin
                    n_received = i_header_word;
                end else begin
                    n_sum = r_sum + {{(SUM_W-16){1'b0}}, i_header_word};
                end
                if (r_word_index == TTL_WORD) begin
                    n_ttl_one = (i_header_word[15:8] == TTL_ONE);
                end
                n_word_index = r_word_index + 5'd1;
                if (n_word_index >= r_len_words) begin
                    n_in_header        = 1'b0;
                    o_rec_valid        = 1'b1;
                    o_rec.sum          = n_sum;
                    o_rec.received     = n_received;
                    o_rec.version_good = r_version_good;
                    o_rec.ttl_one      = n_ttl_one;
                    o_rec.malformed    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header  <= 1'b0;
            r_word_index <= '0;
        end else begin
            r_in_header  <= n_in_header;
            r_word_index <= n_word_index;
        end
        r_len_words    <= n_len_words;
        r_sum          <= n_sum;
        r_received     <= n_received;
        r_version_good <= n_version_good;
        r_ttl_one      <= n_ttl_one;
    end

endmodule

// ===== hw/rtl/ihcc_queue.sv =====
// Short queue of header records between the front and back ends.
module ihcc_queue
    import ihcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_rec i_wr_rec,
    input  logic i_rd,
    output logic o_valid,
    output logic o_full,
    output t_rec o_rd_rec
);

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_valid  = (r_count != '0);
    assign o_full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_rd_rec = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr || i_rd)
        else $error("record written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_rd)
        else $error("record read from an empty queue");

endmodule

// ===== hw/rtl/ihcc_back.sv =====
// Back end: folds and complements the sum, compares it and holds the result item.
module ihcc_back
    import ihcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rec_valid,
    input  t_rec        i_rec,
    output logic        o_rec_take,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [15:0] o_computed_sum,
    output logic [15:0] o_received_sum,
    output logic        o_sum_ok,
    output logic        o_version_ok,
    output logic        o_ttl_is_one,
    output logic        o_malformed
);

    logic        r_valid;
    logic [15:0] r_computed, r_received;
    logic        r_sum_ok, r_version_ok, r_ttl_is_one, r_malformed;

    logic [16:0] fold1, fold2;
    logic [15:0] cksum;

    assign fold1 = {1'b0, i_rec.sum[15:0]} + {12'd0, i_rec.sum[SUM_W-1:16]};
    assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    assign cksum = ~fold2[15:0];

    assign o_rec_take = i_rec_valid && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
        if (o_rec_take) begin
            r_version_ok <= i_rec.version_good;
            r_malformed  <= i_rec.malformed;
            if (i_rec.malformed) begin
                r_computed   <= '0;
                r_received   <= '0;
                r_sum_ok     <= 1'b0;
                r_ttl_is_one <= 1'b0;
            end else begin
                r_computed   <= cksum;
                r_received   <= i_rec.received;
                r_sum_ok     <= (cksum == i_rec.received);
                r_ttl_is_one <= i_rec.ttl_one;
            end
        end
    end

    assign o_empty        = !r_valid;
    assign o_computed_sum = r_computed;
    assign o_received_sum = r_received;
    assign o_sum_ok       = r_sum_ok;
    assign o_version_ok   = r_version_ok;
    assign o_ttl_is_one   = r_ttl_is_one;
    assign o_malformed    = r_malformed;

    a_malformed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_malformed |-> !r_sum_ok && r_computed == '0 && !r_ttl_is_one)
        else $error("malformed result carries checksum fields");

    a_sum_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_sum_ok |-> r_computed == r_received)
        else $error("checksum match flag disagrees with checksums");

endmodule

// ===== hw/rtl/ipv4_header_checksum_check.sv =====
// Top level of the IPv4 header checksum checker.
//
// Header words enter on a queue-style port: a word is taken at a rising edge
// where push is high and full is low. The first word of a header carries
// i_start_flag. Words outside a header are dropped, and a new start word
// abandons an unfinished header without a result.
// One result item is produced per completed header, or at once for a start
// word whose header length is below five. Results leave on a queue-style
// port: while empty is low the oldest item is on the o_ ports, and it is
// taken at an edge where pop is high.
// A result passes from the front end through the record queue and into the
// result register before it reaches the ports. Throughput: one word per cycle
// while full is low; the front end does one 21-bit add per word.
// A two-entry record queue and a result register sit between the front end
// and the receiver, so a stalled receiver fills them and only then raises full.
// Synchronous reset empties the queue and result register and closes any
// open header.
module ipv4_header_checksum_check
    import ihcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_header_word,
    input  logic        i_start_flag,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_computed_sum,
    output logic [15:0] o_received_sum,
    output logic        o_sum_ok,
    output logic        o_version_ok,
    output logic        o_ttl_is_one,
    output logic        o_malformed
);

    logic accept;
    logic front_valid;
    t_rec front_rec;
    logic q_valid;
    logic q_full;
    t_rec q_rec;
    logic q_take;

    assign full   = q_full;
    assign accept = push && !q_full;

    ihcc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_header_word (i_header_word),
        .i_start_flag  (i_start_flag),
        .o_rec_valid   (front_valid),
        .o_rec         (front_rec)
    );

    ihcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_valid),
        .i_wr_rec (front_rec),
        .i_rd     (q_take),
        .o_valid  (q_valid),
        .o_full   (q_full),
        .o_rd_rec (q_rec)
    );

    ihcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec_valid    (q_valid),
        .i_rec          (q_rec),
        .o_rec_take     (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_computed_sum (o_computed_sum),
        .o_received_sum (o_received_sum),
        .o_sum_ok       (o_sum_ok),
        .o_version_ok   (o_version_ok),
        .o_ttl_is_one   (o_ttl_is_one),
        .o_malformed    (o_malformed)
    );

endmodule
